### src/rgd_pkg.sv
package rgd_pkg;

  localparam int MAC_BITS = 48;
  localparam int NOW_BITS = 32;
  localparam int CFG_DATA_BITS = 16;
  localparam int INTERVAL_BITS = 16;
  localparam int MAX_ENTRIES_BITS = 6;

  localparam int DEFAULT_TABLE_DEPTH = 64;
  localparam int DEFAULT_TIME_BITS = 32;

  typedef enum logic [1:0] {
    CFG_GUARD_ENABLE    = 2'd0,
    CFG_RENEW_ON_REJECT = 2'd1,
    CFG_MIN_INTERVAL    = 2'd2,
    CFG_MAX_ENTRIES     = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    VERDICT_PASSED  = 2'd0,
    VERDICT_LEARNED = 2'd1,
    VERDICT_ALLOWED = 2'd2,
    VERDICT_DROPPED = 2'd3
  } verdict_t;

endpackage

### src/rgd_req_if.sv
interface rgd_req_if;
  import rgd_pkg::*;
  logic                valid;
  logic                ready;
  logic [MAC_BITS-1:0] client_mac;
  logic [NOW_BITS-1:0] now_seconds;
  logic                already_dropped;

  modport source (output valid, client_mac, now_seconds, already_dropped, input ready);
  modport sink   (input valid, client_mac, now_seconds, already_dropped, output ready);
endinterface

### src/rgd_rsp_if.sv
interface rgd_rsp_if;
  import rgd_pkg::*;
  logic     valid;
  logic     ready;
  verdict_t verdict;
  logic     drop;
  logic     table_cleared;

  modport source (output valid, verdict, drop, table_cleared, input ready);
  modport sink   (input valid, verdict, drop, table_cleared, output ready);
endinterface

### src/rgd_cfg_if.sv
interface rgd_cfg_if;
  import rgd_pkg::*;
  logic                     valid;
  logic                     ready;
  cfg_index_t               index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/rgd_ram.sv
module rgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/per_mac_request_rate_guard_unit.sv
// channel  role    handshake      payload
// req      sink    valid/ready    client_mac, now_seconds, already_dropped
// rsp      source  valid/ready    verdict, drop, table_cleared
// cfg      sink    valid/ready    index, data (ready held high)
//
// a bypassed request goes straight to the finish state; a guarded request scans
// the table memory, one stored entry per cycle, then passes the decide state on
// a hit or the miss state, which stores the new entry, before the finish state
// rst zeroes state and config registers and empties the table (fill count to zero)
// a finished result waits in the output register; the next request is taken
// meanwhile, and a second result holds until the first one transfers
module per_mac_request_rate_guard_unit
  import rgd_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int TIME_BITS   = DEFAULT_TIME_BITS
) (
  input logic      clk,
  input logic      rst,
  rgd_req_if.sink  req,
  rgd_rsp_if.source rsp,
  rgd_cfg_if.sink  cfg
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int EW   = MAC_BITS + TIME_BITS;
  localparam int CMPW = (CW > MAX_ENTRIES_BITS) ? CW : MAX_ENTRIES_BITS;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MISS, S_DECIDE, S_FINISH} state_t;

  state_t                     state;
  logic                       guard_enable;
  logic                       renew_on_reject;
  logic [INTERVAL_BITS-1:0]   min_interval;
  logic [MAX_ENTRIES_BITS-1:0] max_entries;
  logic [CW-1:0]              count;
  logic [CW-1:0]              idx;
  logic                       pend;
  logic [AW-1:0]              pidx;
  logic [AW-1:0]              hit_idx;
  logic [TIME_BITS-1:0]       hit_time;
  logic [MAC_BITS-1:0]        mac_q;
  logic [TIME_BITS-1:0]       now_q;
  logic                       cleared_q;
  verdict_t                   res_verdict;
  logic                       res_drop;
  logic                       out_valid;
  verdict_t                   out_verdict;
  logic                       out_drop;
  logic                       out_cleared;

  logic [63:0]                now_w;
  logic [TIME_BITS-1:0]       now_t;
  logic                       overflow;
  logic                       issue;
  logic                       match;
  logic [TIME_BITS-1:0]       diff;
  logic                       too_recent;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [EW-1:0]              ram_rdata;

  assign now_w    = 64'(req.now_seconds);
  assign now_t    = now_w[TIME_BITS-1:0];
  assign overflow = (CMPW'(count) > CMPW'(max_entries)) || (count >= CW'(TABLE_DEPTH));

  assign issue = (idx != count);
  assign match = pend && (ram_rdata[EW-1:TIME_BITS] == mac_q);

  assign diff       = now_q - hit_time;
  assign too_recent = diff[TIME_BITS-1] || (diff < TIME_BITS'(min_interval));

  assign ram_we    = (state == S_MISS) || ((state == S_DECIDE) && too_recent && renew_on_reject);
  assign ram_waddr = (state == S_MISS) ? count[AW-1:0] : hit_idx;

  rgd_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({mac_q, now_q}),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign req.ready         = (state == S_IDLE);
  assign cfg.ready         = 1'b1;
  assign rsp.valid         = out_valid;
  assign rsp.verdict       = out_verdict;
  assign rsp.drop          = out_drop;
  assign rsp.table_cleared = out_cleared;

  // fill count: rst, any register write or an overflow empties the table
  always_ff @(posedge clk) begin
    if (rst || cfg.valid) begin
      count <= '0;
    end else if ((state == S_IDLE) && req.valid && !req.already_dropped && guard_enable
                 && overflow) begin
      count <= '0;
    end else if (state == S_MISS) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      guard_enable    <= 1'b0;
      renew_on_reject <= 1'b0;
      min_interval    <= '0;
      max_entries     <= '0;
      idx             <= '0;
      pend            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            mac_q <= req.client_mac;
            now_q <= now_t;
            if (req.already_dropped || !guard_enable) begin
              cleared_q   <= 1'b0;
              res_verdict <= VERDICT_PASSED;
              res_drop    <= 1'b0;
              state       <= S_FINISH;
            end else begin
              cleared_q <= overflow;
              idx   <= '0;
              pend  <= 1'b0;
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          pend <= issue;
          pidx <= idx[AW-1:0];
          if (issue) begin
            idx <= idx + CW'(1);
          end
          if (match) begin
            hit_idx  <= pidx;
            hit_time <= ram_rdata[TIME_BITS-1:0];
            state    <= S_DECIDE;
          end else if (!issue && !pend) begin
            state <= S_MISS;
          end
        end

        S_MISS: begin
          res_verdict <= VERDICT_LEARNED;
          res_drop    <= 1'b0;
          state       <= S_FINISH;
        end

        S_DECIDE: begin
          res_verdict <= too_recent ? VERDICT_DROPPED : VERDICT_ALLOWED;
          res_drop    <= too_recent;
          state       <= S_FINISH;
        end

        S_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_verdict <= res_verdict;
            out_drop    <= res_drop;
            out_cleared <= cleared_q;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_GUARD_ENABLE:    guard_enable    <= cfg.data[0];
          CFG_RENEW_ON_REJECT: renew_on_reject <= cfg.data[0];
          CFG_MIN_INTERVAL:    min_interval    <= cfg.data[INTERVAL_BITS-1:0];
          CFG_MAX_ENTRIES:     max_entries     <= cfg.data[MAX_ENTRIES_BITS-1:0];
          default:             guard_enable    <= guard_enable;
        endcase
      end
    end
  end

endmodule
